FILE: src/mfc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfc_pkg
// Shared types, codes and digit helpers for the memory, flag and command
// word unit.
// ----------------------------------------------------------------------------
package mfc_pkg;

  localparam int MemWords = 100;
  localparam int MemAddrW = (MemWords > 1) ? $clog2(MemWords) : 1;

  localparam int WordW    = 16;
  localparam int FuncW    = 3;
  localparam int AddrW    = 7;
  localparam int FlagNumW = 3;
  localparam int CodeW    = 7;
  localparam int StatusW  = 3;
  localparam int FlagsW   = 5;

  // Operation codes.
  localparam logic [FuncW-1:0] FnMemWrite  = 3'd0;
  localparam logic [FuncW-1:0] FnMemRead   = 3'd1;
  localparam logic [FuncW-1:0] FnFlagWrite = 3'd2;
  localparam logic [FuncW-1:0] FnFlagRead  = 3'd3;
  localparam logic [FuncW-1:0] FnEncode    = 3'd4;
  localparam logic [FuncW-1:0] FnDecode    = 3'd5;

  // Status codes.
  localparam logic [StatusW-1:0] StOk       = 3'd0;
  localparam logic [StatusW-1:0] StMemory   = 3'd1;
  localparam logic [StatusW-1:0] StBadFlag  = 3'd2;
  localparam logic [StatusW-1:0] StBadValue = 3'd3;
  localparam logic [StatusW-1:0] StUnknown  = 3'd4;
  localparam logic [StatusW-1:0] StOperand  = 3'd5;

  // Flag numbers that the unit raises itself.
  localparam logic [FlagNumW-1:0] FlagOverflow = 3'd1;
  localparam logic [FlagNumW-1:0] FlagMemory   = 3'd3;
  localparam logic [FlagNumW-1:0] FlagUnknown  = 3'd5;

  localparam logic [CodeW-1:0] MaxOperand = 7'd79;

  typedef struct packed {
    logic [FuncW-1:0]    func;
    logic [AddrW-1:0]    address;
    logic [WordW-1:0]    data_word;
    logic [FlagNumW-1:0] flag_number;
    logic [CodeW-1:0]    command_code;
    logic [CodeW-1:0]    operand_value;
  } item_t;

  typedef struct packed {
    logic [WordW-1:0]   result_word;
    logic               flag_bit;
    logic [StatusW-1:0] status;
    logic [CodeW-1:0]   command_out;
    logic [CodeW-1:0]   operand_out;
  } result_t;

  function automatic logic opcode_known(input logic [CodeW-1:0] c);
    return (c == 7'd10) || (c == 7'd11) || (c == 7'd20) || (c == 7'd21) ||
           (c >= 7'd30 && c <= 7'd33) || (c >= 7'd40 && c <= 7'd43) ||
           (c >= 7'd51 && c <= 7'd76);
  endfunction

  // Binary to two-digit BCD, truncated to seven bits. The tens digit uses
  // a reciprocal multiply that is exact for all seven-bit values.
  function automatic logic [CodeW-1:0] to_bcd(input logic [CodeW-1:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [7:0]  sum;
    prod = 15'(v) * 15'd205;
    tens = prod[14:11];
    sum  = 8'(v) + 8'(tens) * 8'd6;
    return sum[CodeW-1:0];
  endfunction

  // Weight a nibble pair as high * 10 + low.
  function automatic logic [CodeW-1:0] pair_weight(input logic [CodeW-1:0] v);
    logic [CodeW-1:0] hi;
    hi = 7'(v[6:4]) * 7'd10;
    return hi + 7'(v[3:0]);
  endfunction

endpackage
`default_nettype wire

FILE: src/mfc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mfc_ram #(
  parameter int Width = 16,
  parameter int Depth = 100,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] waddr,
  input  wire logic [Width-1:0] wdata,
  input  wire logic [AddrW-1:0] raddr,
  output logic      [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: src/mfc_exec.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfc_exec
// Execute logic: bounds and flag checks, BCD encode and decode, and the
// next value of the flag register for one transaction.
// ----------------------------------------------------------------------------
module mfc_exec (
  input  wire mfc_pkg::item_t                  item,
  input  wire logic [mfc_pkg::WordW-1:0]       mem_data,
  input  wire logic [mfc_pkg::FlagsW-1:0]      flags,
  output mfc_pkg::result_t                     res,
  output logic      [mfc_pkg::FlagsW-1:0]      flags_nxt
);

  logic                            addr_ok;
  logic                            fnum_ok;
  logic [mfc_pkg::FlagsW-1:0]      fmask;
  logic [mfc_pkg::CodeW-1:0]       dec_cmd;
  logic [mfc_pkg::CodeW-1:0]       dec_opv;

  assign addr_ok = {1'b0, item.address} < 8'(mfc_pkg::MemWords);
  assign fnum_ok = (item.flag_number >= 3'd1) && (item.flag_number <= 3'd5);
  assign fmask   = 5'(5'd1 << (item.flag_number - 3'd1));
  assign dec_cmd = mfc_pkg::pair_weight(item.data_word[13:7]);
  assign dec_opv = mfc_pkg::pair_weight(item.data_word[6:0]);

  always_comb begin
    res       = '0;
    flags_nxt = flags;
    case (item.func)
      mfc_pkg::FnMemWrite: begin
        if (!addr_ok) begin
          flags_nxt[mfc_pkg::FlagMemory - 3'd1] = 1'b1;
          res.status = mfc_pkg::StMemory;
        end
      end
      mfc_pkg::FnMemRead: begin
        if (addr_ok) begin
          res.result_word = mem_data;
        end else begin
          flags_nxt[mfc_pkg::FlagMemory - 3'd1] = 1'b1;
          res.status = mfc_pkg::StMemory;
        end
      end
      mfc_pkg::FnFlagWrite: begin
        if (!fnum_ok) begin
          res.status = mfc_pkg::StBadFlag;
        end else if (item.data_word == 16'd1) begin
          flags_nxt = flags | fmask;
        end else if (item.data_word == 16'd0) begin
          flags_nxt = flags & ~fmask;
        end else begin
          res.status = mfc_pkg::StBadValue;
        end
      end
      mfc_pkg::FnFlagRead: begin
        if (!fnum_ok) begin
          res.status = mfc_pkg::StBadFlag;
        end else begin
          res.flag_bit = |(flags & fmask);
        end
      end
      mfc_pkg::FnEncode: begin
        if (!mfc_pkg::opcode_known(item.command_code)) begin
          flags_nxt[mfc_pkg::FlagUnknown - 3'd1] = 1'b1;
          res.status = mfc_pkg::StUnknown;
        end else if (item.operand_value > mfc_pkg::MaxOperand) begin
          flags_nxt[mfc_pkg::FlagOverflow - 3'd1] = 1'b1;
          res.status = mfc_pkg::StOperand;
        end else begin
          res.result_word = {2'b00, mfc_pkg::to_bcd(item.command_code),
                             mfc_pkg::to_bcd(item.operand_value)};
        end
      end
      mfc_pkg::FnDecode: begin
        res.command_out = dec_cmd;
        res.operand_out = dec_opv;
        if (!mfc_pkg::opcode_known(dec_cmd) || dec_opv > mfc_pkg::MaxOperand) begin
          flags_nxt[mfc_pkg::FlagUnknown - 3'd1] = 1'b1;
          res.status = mfc_pkg::StUnknown;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: src/memory_flags_command_codec.sv
`default_nettype none
// ----------------------------------------------------------------------------
// memory_flags_command_codec
// Word memory, five-bit flag register and BCD command word encode/decode.
// ----------------------------------------------------------------------------
// The start cycle registers the transaction into item_r; its result then goes into res_r with the strobe.
// Throughput: one transaction per cycle; busy stays low.
// Memory writes go in at the start edge, so a read in the next cycle sees them.
// Reset clears the flags, the pipeline strobes and the per-word valid bits,
// so every memory word reads as zero until written. No clearing pass is needed.
// The receiver cannot stall; each result is shown for one cycle.
module memory_flags_command_codec (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic        [mfc_pkg::FuncW-1:0]    in_func,
  input  wire logic        [mfc_pkg::AddrW-1:0]    in_address,
  input  wire logic signed [mfc_pkg::WordW-1:0]    in_data_word,
  input  wire logic        [mfc_pkg::FlagNumW-1:0] in_flag_number,
  input  wire logic        [mfc_pkg::CodeW-1:0]    in_command_code,
  input  wire logic        [mfc_pkg::CodeW-1:0]    in_operand_value,
  output logic                                    out_strobe,
  output logic signed      [mfc_pkg::WordW-1:0]    out_result_word,
  output logic                                    out_flag_bit,
  output logic             [mfc_pkg::StatusW-1:0]  out_status,
  output logic             [mfc_pkg::CodeW-1:0]    out_command_out,
  output logic             [mfc_pkg::CodeW-1:0]    out_operand_out,
  output logic             [mfc_pkg::FlagsW-1:0]   out_flag_register
);

  logic                              accept;
  logic                              addr_ok;
  logic                              mem_we;
  logic [mfc_pkg::MemAddrW-1:0]      mem_addr;
  logic [mfc_pkg::WordW-1:0]         ram_rdata;
  logic [mfc_pkg::WordW-1:0]         mem_data;

  logic [mfc_pkg::MemWords-1:0]      valid_r;
  logic                              rd_valid_r;
  logic                              in_valid_r;
  mfc_pkg::item_t                    item_r;
  logic [mfc_pkg::FlagsW-1:0]        flags_r;
  logic [mfc_pkg::FlagsW-1:0]        flags_nxt;
  mfc_pkg::result_t                  res_nxt;
  mfc_pkg::result_t                  res_r;
  logic                              out_strobe_r;

  // There is no stall condition, so busy is tied low.
  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign addr_ok = {1'b0, in_address} < 8'(mfc_pkg::MemWords);
  assign mem_we  = accept && (in_func == mfc_pkg::FnMemWrite) && addr_ok;
  assign mem_addr = in_address[mfc_pkg::MemAddrW-1:0];

  mfc_ram #(
    .Width (mfc_pkg::WordW),
    .Depth (mfc_pkg::MemWords)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_addr),
    .wdata (in_data_word),
    .raddr (mem_addr),
    .rdata (ram_rdata)
  );

  // A word never written reads as zero.
  assign mem_data = rd_valid_r ? ram_rdata : '0;

  mfc_exec u_exec (
    .item      (item_r),
    .mem_data  (mem_data),
    .flags     (flags_r),
    .res       (res_nxt),
    .flags_nxt (flags_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      in_valid_r   <= 1'b0;
      out_strobe_r <= 1'b0;
      flags_r      <= '0;
    end else begin
      in_valid_r   <= accept;
      out_strobe_r <= in_valid_r;
      if (mem_we) begin
        valid_r[mem_addr] <= 1'b1;
      end
      if (in_valid_r) begin
        flags_r <= flags_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_valid_r <= addr_ok ? valid_r[mem_addr] : 1'b0;
    if (accept) begin
      item_r <= '{func:          in_func,
                  address:       in_address,
                  data_word:     in_data_word,
                  flag_number:   in_flag_number,
                  command_code:  in_command_code,
                  operand_value: in_operand_value};
    end
    if (in_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_result_word   = res_r.result_word;
  assign out_flag_bit      = res_r.flag_bit;
  assign out_status        = res_r.status;
  assign out_command_out   = res_r.command_out;
  assign out_operand_out   = res_r.operand_out;
  assign out_flag_register = flags_r;

`ifndef SYNTHESIS
  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r |=> out_strobe_r)
    else $error("result strobe missing after execute stage");

  a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |=> $stable(flags_r))
    else $error("flag register changed without a transaction");

  a_mem_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && res_r.status == mfc_pkg::StMemory) |->
      flags_r[mfc_pkg::FlagMemory - 3'd1])
    else $error("memory access error without memory flag");
`endif

endmodule
`default_nettype wire
